@@ hdl/ioc_pkg.sv @@
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared types, constants and helpers of the I/O override controller.
// ----------------------------------------------------------------------------
package ioc_pkg;

    localparam int TimerBits = 16;

    localparam logic [2:0] ErrOk       = 3'd0;
    localparam logic [2:0] ErrSession  = 3'd1;
    localparam logic [2:0] ErrSecurity = 3'd2;
    localparam logic [2:0] ErrLength   = 3'd3;
    localparam logic [2:0] ErrSubfunc  = 3'd4;
    localparam logic [2:0] ErrRange    = 3'd5;

    localparam logic [7:0] CtlReturn = 8'd0;
    localparam logic [7:0] CtlReset  = 8'd1;
    localparam logic [7:0] CtlFreeze = 8'd2;
    localparam logic [7:0] CtlAdjust = 8'd3;

    localparam logic [15:0] SigLed   = 16'd1;
    localparam logic [15:0] SigBuz   = 16'd2;
    localparam logic [15:0] SigFan   = 16'd3;
    localparam logic [15:0] SigRelay = 16'd4;

    localparam logic [0:0] RegBuzPeriod = 1'd0;
    localparam logic [0:0] RegFanPeriod = 1'd1;

    localparam logic [15:0] PeriodReset = 16'd999;

    // Reciprocal of 125 scaled by 2^37, exact for dividends below 2^30.
    localparam logic [30:0] BlinkRecip = 31'd1099511628;
    // Reciprocal of 25 scaled by 2^26, exact for dividends below 2^21.
    localparam logic [21:0] DivHundredRecip = 22'd2684355;

    typedef struct packed {
        logic        mode;
        logic [7:0]  msg_len;
        logic [15:0] signal_id;
        logic [7:0]  control_type;
        logic [7:0]  adjust_value;
        logic [7:0]  service_byte;
        logic        in_default_session;
        logic        security_unlocked;
        logic [7:0]  temperature;
        logic [31:0] time_ms;
    } t_in;

    typedef struct packed {
        logic        is_response;
        logic        is_negative;
        logic [2:0]  error_code;
        logic [7:0]  echo_service;
        logic [15:0] echo_signal;
        logic [7:0]  echo_control;
        logic        led_on;
        logic        relay_closed;
        logic [15:0] buzzer_compare;
        logic [15:0] fan_compare;
    } t_out;

    typedef struct packed {
        logic        index;
        logic [15:0] data;
    } t_cfg;

    // Classified job passed from the front to the back.
    typedef struct packed {
        logic        tick;
        logic [2:0]  err;
        logic [7:0]  val;
        logic [7:0]  svc;
        logic [15:0] signal_id;
        logic [7:0]  control_type;
        logic        blink_on;
        logic [6:0]  fan_duty;
    } t_job;

    function automatic logic [15:0] mask_period(input logic [15:0] p);
        return p & 16'((33'd1 << TimerBits) - 33'd1);
    endfunction

    function automatic logic [6:0] clamp_duty(input logic [7:0] d);
        return (d > 8'd100) ? 7'd100 : d[6:0];
    endfunction

endpackage

@@ hdl/ioc_if.sv @@
// ----------------------------------------------------------------------------
// ioc_if
// Valid/ready channels of the controller.
// ----------------------------------------------------------------------------
interface ioc_in_if;
    logic          valid;
    logic          ready;
    ioc_pkg::t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ioc_out_if;
    logic          valid;
    logic          ready;
    ioc_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ioc_cfg_if;
    logic          valid;
    logic          ready;
    ioc_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/ioc_front.sv @@
// ----------------------------------------------------------------------------
// ioc_front
// Accepts input beats and classifies them into jobs for the back end.
// ----------------------------------------------------------------------------
module ioc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ioc_in_if.sink        in_ch,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output ioc_pkg::t_job o_job
);

    logic          r_valid;
    ioc_pkg::t_job r_job;
    ioc_pkg::t_job n_job;
    ioc_pkg::t_in  w_in;
    logic [60:0]   w_prod;

    assign w_in = in_ch.payload;
    assign in_ch.ready = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job = r_job;

    // The LED is lit in the first half of each second, that is when time_ms / 500
    // is even; the quotient is time_ms / 4 times the reciprocal of 125.
    assign w_prod = 61'(w_in.time_ms[31:2]) * 61'(ioc_pkg::BlinkRecip);

    always_comb begin
        n_job = '0;
        n_job.tick = w_in.mode;
        n_job.val = w_in.adjust_value;
        n_job.svc = w_in.service_byte;
        n_job.signal_id = w_in.signal_id;
        n_job.control_type = w_in.control_type;
        n_job.blink_on = !w_prod[37];
        n_job.fan_duty = (w_in.temperature > 8'd80) ? 7'd100 :
                         (w_in.temperature > 8'd60) ? 7'd70 :
                         (w_in.temperature > 8'd40) ? 7'd50 : 7'd30;
        if (w_in.in_default_session) begin
            n_job.err = ioc_pkg::ErrSession;
        end else if (!w_in.security_unlocked) begin
            n_job.err = ioc_pkg::ErrSecurity;
        end else if (w_in.msg_len < 8'd4 || w_in.msg_len > 8'd5) begin
            n_job.err = ioc_pkg::ErrLength;
        end else if (w_in.control_type == ioc_pkg::CtlAdjust && w_in.msg_len != 8'd5) begin
            n_job.err = ioc_pkg::ErrLength;
        end else if (w_in.signal_id < ioc_pkg::SigLed
                     || w_in.signal_id > ioc_pkg::SigRelay) begin
            n_job.err = ioc_pkg::ErrRange;
        end else if (w_in.control_type > ioc_pkg::CtlAdjust) begin
            n_job.err = ioc_pkg::ErrSubfunc;
        end else begin
            n_job.err = ioc_pkg::ErrOk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_ch.valid && in_ch.ready) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) begin
            r_job <= n_job;
        end
    end

endmodule

@@ hdl/ioc_divider.sv @@
// ----------------------------------------------------------------------------
// ioc_divider
// Restoring divider of a 24-bit numerator by a 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ioc_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [23:0] o_quot
);

    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [23:0] r_quot;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [16:0] w_trial;
    logic [17:0] w_diff;

    assign w_trial = {r_rem[15:0], r_quot[23]};
    assign w_diff = {1'b0, w_trial} - {2'b0, r_den};
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd23;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                r_rem <= w_diff[16:0];
                r_quot <= {r_quot[22:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quot <= {r_quot[22:0], 1'b0};
            end
        end
    end

endmodule

@@ hdl/ioc_back.sv @@
// ----------------------------------------------------------------------------
// ioc_back
// Carries out jobs on the output state and forms result beats.
// ----------------------------------------------------------------------------
module ioc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    input  ioc_pkg::t_job i_job,
    input  logic [15:0]   i_buz_period,
    input  logic [15:0]   i_fan_period,
    ioc_out_if.source     out_ch
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_PCT   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_MULT  = 7'b0010000,
        S_SCALE = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state        r_state;
    ioc_pkg::t_job r_job;
    logic          r_led;
    logic          r_relay;
    logic [15:0]   r_buz;
    logic [15:0]   r_fan;
    logic [3:0]    r_ovr;
    logic          r_is_fan;
    logic [6:0]    r_duty;
    logic [22:0]   r_prod;
    logic          r_start;
    logic [23:0]   r_num;
    logic [15:0]   r_den;
    logic          r_ovalid;
    ioc_pkg::t_out r_out;
    logic          w_done;
    logic [23:0]   w_quot;
    logic [15:0]   w_per;
    logic [6:0]    w_pct;
    logic [42:0]   w_scaled;
    logic [15:0]   w_cmp;
    logic          w_ok;
    logic          w_out_free;

    ioc_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_start),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign w_per = ioc_pkg::mask_period(r_is_fan ? i_fan_period : i_buz_period);
    assign w_pct = (w_quot > 24'd100) ? 7'd100 : w_quot[6:0];
    // Compare = (period * duty / 4) / 25, the division by the reciprocal of 25.
    assign w_scaled = 43'(r_prod[22:2]) * 43'(ioc_pkg::DivHundredRecip);
    assign w_cmp = w_scaled[41:26];
    assign w_ok = !r_job.tick && r_job.err == ioc_pkg::ErrOk;
    assign w_out_free = !r_ovalid || out_ch.ready;
    assign o_job_ready = r_state == S_IDLE;
    assign out_ch.valid = r_ovalid;
    assign out_ch.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_led <= 1'b0;
            r_relay <= 1'b0;
            r_buz <= '0;
            r_fan <= '0;
            r_ovr <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_job.tick) begin
                        if (!r_ovr[0]) begin
                            r_led <= r_job.blink_on;
                        end
                        if (!r_ovr[1]) begin
                            r_buz <= '0;
                        end
                        if (!r_ovr[2]) begin
                            r_is_fan <= 1'b1;
                            r_duty <= r_job.fan_duty;
                            r_state <= S_MULT;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (w_ok) begin
                        unique case (r_job.signal_id)
                            ioc_pkg::SigLed: begin
                                r_ovr[0] <= r_job.control_type != ioc_pkg::CtlReturn;
                                if (r_job.control_type == ioc_pkg::CtlReset) begin
                                    r_led <= 1'b0;
                                end else if (r_job.control_type == ioc_pkg::CtlAdjust) begin
                                    r_led <= r_job.val != 8'd0;
                                end
                                r_state <= S_OUT;
                            end
                            ioc_pkg::SigBuz, ioc_pkg::SigFan: begin
                                r_is_fan <= r_job.signal_id == ioc_pkg::SigFan;
                                if (r_job.signal_id == ioc_pkg::SigFan) begin
                                    r_ovr[2] <= r_job.control_type != ioc_pkg::CtlReturn;
                                end else begin
                                    r_ovr[1] <= r_job.control_type != ioc_pkg::CtlReturn;
                                end
                                unique case (r_job.control_type)
                                    ioc_pkg::CtlReturn: begin
                                        r_state <= S_OUT;
                                    end
                                    ioc_pkg::CtlReset: begin
                                        r_duty <= (r_job.signal_id == ioc_pkg::SigFan) ?
                                                  7'd30 : 7'd0;
                                        r_state <= S_MULT;
                                    end
                                    ioc_pkg::CtlFreeze: begin
                                        r_state <= S_PCT;
                                    end
                                    default: begin
                                        r_duty <= ioc_pkg::clamp_duty(r_job.val);
                                        r_state <= S_MULT;
                                    end
                                endcase
                            end
                            default: begin
                                r_ovr[3] <= r_job.control_type != ioc_pkg::CtlReturn;
                                if (r_job.control_type == ioc_pkg::CtlReset) begin
                                    r_relay <= 1'b0;
                                end else if (r_job.control_type == ioc_pkg::CtlAdjust) begin
                                    r_relay <= r_job.val == 8'd1;
                                end
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_PCT: begin
                    // Readback = compare * 100 / period, capped at 100, zero for a zero period.
                    if (w_per == 16'd0) begin
                        r_duty <= '0;
                        r_state <= S_MULT;
                    end else begin
                        r_num <= 24'(r_is_fan ? r_fan : r_buz) * 24'd100;
                        r_den <= w_per;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        r_duty <= w_pct;
                        r_state <= S_MULT;
                    end
                end
                S_MULT: begin
                    r_prod <= 23'(w_per) * 23'(r_duty);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    if (r_is_fan) begin
                        r_fan <= w_cmp;
                    end else begin
                        r_buz <= w_cmp;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out.is_response <= !r_job.tick;
                        r_out.is_negative <= !r_job.tick && r_job.err != ioc_pkg::ErrOk;
                        r_out.error_code <= r_job.tick ? ioc_pkg::ErrOk : r_job.err;
                        r_out.echo_service <= (!r_job.tick && !w_ok) ? r_job.svc : 8'd0;
                        r_out.echo_signal <= w_ok ? r_job.signal_id : 16'd0;
                        r_out.echo_control <= w_ok ? r_job.control_type : 8'd0;
                        r_out.led_on <= r_led;
                        r_out.relay_closed <= r_relay;
                        r_out.buzzer_compare <= r_buz;
                        r_out.fan_compare <= r_fan;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= r_state == S_PCT && w_per != 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

endmodule

@@ hdl/io_override_controller.sv @@
// ----------------------------------------------------------------------------
// io_override_controller
// Diagnostic I/O control of LED, buzzer, fan and relay, with periodic tick.
// ----------------------------------------------------------------------------
// A plain request, or a tick with the fan overridden, goes from READ to OUT; a PWM
// compare is formed by reciprocal multiplication in MULT and SCALE, and a PWM freeze
// first reads back the duty through PCT and the 24-step bit-serial divider, which
// a zero period skips. The back end takes one job at a time; the front holds one
// more beat, and a result stalled at the output holds the back end until taken.
// Synchronous active-low reset restores periods to 999 and clears control state only.
module io_override_controller (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ioc_in_if.sink    in_ch,
    ioc_cfg_if.sink   cfg_ch,
    ioc_out_if.source out_ch
);

    logic          w_job_valid;
    logic          w_job_ready;
    ioc_pkg::t_job w_job;
    logic [15:0]   r_buz_period;
    logic [15:0]   r_fan_period;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buz_period <= ioc_pkg::PeriodReset;
            r_fan_period <= ioc_pkg::PeriodReset;
        end else if (cfg_ch.valid) begin
            if (cfg_ch.payload.index == ioc_pkg::RegBuzPeriod) begin
                r_buz_period <= cfg_ch.payload.data;
            end else begin
                r_fan_period <= cfg_ch.payload.data;
            end
        end
    end

    ioc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .o_job_valid(w_job_valid),
        .i_job_ready(w_job_ready),
        .o_job      (w_job)
    );

    ioc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .i_job       (w_job),
        .i_buz_period(r_buz_period),
        .i_fan_period(r_fan_period),
        .out_ch      (out_ch)
    );

endmodule

@@ hdl/ioc_checker.sv @@
// ----------------------------------------------------------------------------
// ioc_checker
// Port-level checks of the I/O override controller.
// ----------------------------------------------------------------------------
module ioc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          out_valid,
    input logic          out_ready,
    input ioc_pkg::t_out out_payload
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("Stalled result beat changed.");

    a_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_payload.is_response |->
        !out_payload.is_negative && out_payload.error_code == ioc_pkg::ErrOk)
        else $error("Tick result carries an error.");

    a_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_payload.is_negative == (out_payload.error_code != ioc_pkg::ErrOk))
        else $error("Negative flag disagrees with error code.");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_payload.error_code <= ioc_pkg::ErrRange)
        else $error("Error code out of range.");

endmodule

bind io_override_controller ioc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_payload(out_ch.payload)
);
